@@ hdl/lz78_token_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// lz78 token decoder assertion macros
// shared checks on a clk_i / rst_ni clock domain
// ----------------------------------------------------------------------------
`ifndef LZ78_TOKEN_DECODER_ASSERT_SVH
`define LZ78_TOKEN_DECODER_ASSERT_SVH

// same-cycle implication
`define LZD_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lz78 token decoder check failed");

// next-cycle implication
`define LZD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lz78 token decoder check failed");

`endif

@@ hdl/lz78d_pkg.sv @@
// ----------------------------------------------------------------------------
// lz78d_pkg
// types, constants and codes shared by the lz78 token decoder modules
// ----------------------------------------------------------------------------
package lz78d_pkg;

  localparam int unsigned DICT_DEPTH = 4096;
  localparam int unsigned MAX_PHRASE = 64;

  localparam int unsigned DICT_AW = $clog2(DICT_DEPTH);
  localparam int unsigned BUF_AW  = $clog2(MAX_PHRASE);
  localparam int unsigned LEN_W   = $clog2(MAX_PHRASE + 1);
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned FS_W    = 32;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_LONG = 2'd2;

  localparam logic REG_FRAME_SIZE  = 1'b0;
  localparam logic REG_MAX_ENTRIES = 1'b1;

  typedef enum logic [1:0] {
    PH_COLLECT  = 2'd0,
    PH_DONE     = 2'd1,
    PH_ERR_BAD  = 2'd2,
    PH_ERR_LONG = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] prefix;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic               re;
    logic [DICT_AW-1:0] raddr;
    logic               we;
    logic [DICT_AW-1:0] waddr;
    entry_t             wentry;
  } dict_req_t;

  typedef struct packed {
    logic [FS_W-1:0]  frame_size;
    logic [IDX_W-1:0] max_entries;
    logic             fs_we;
    logic [FS_W-1:0]  fs_wdata;
  } cfg_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_byte;
    logic [1:0]       status;
    logic             frame_done;
    logic             last;
  } res_t;

endpackage

@@ hdl/lz78d_dict.sv @@
// ----------------------------------------------------------------------------
// lz78d_dict
// dictionary store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lz78d_dict import lz78d_pkg::*; (
  input  logic      clk_i,
  input  dict_req_t req_i,
  output entry_t    rdata_o
);

  entry_t mem [DICT_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wentry;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lz78d_ctrl.sv @@
// ----------------------------------------------------------------------------
// lz78d_ctrl
// token sequencer: checks, dictionary update, prefix walk into the phrase buffer, byte and error emission
// ----------------------------------------------------------------------------
module lz78d_ctrl import lz78d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             tag_i,
  input  logic [IDX_W-1:0] ref_idx_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  cfg_t             cfg_i,
  output dict_req_t        dict_req_o,
  input  entry_t           dict_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [FS_W-1:0]  bytes_q, bytes_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic [LEN_W-1:0] e_q, e_d;
  logic             zero_q, zero_d;

  logic             tag_q;
  logic [IDX_W-1:0] idx_q;
  logic [SYM_W-1:0] sym_q;
  logic [LEN_W-1:0] plen_q, olen_q;
  logic             load_tok, load_len;

  logic [SYM_W-1:0] buf_mem [MAX_PHRASE];
  logic [SYM_W-1:0] buf_rd_q;
  logic             buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  logic [SYM_W-1:0] buf_wdata;

  logic [LEN_W-1:0] plen_c;
  logic [LEN_W:0]   olen_c;
  logic [FS_W:0]    next_c;
  logic [FS_W-1:0]  bytes_inc;
  logic             fd_c, last_c;
  logic [IDX_W-1:0] pref_m1;

  always_comb begin
    plen_c    = (idx_q == '0) ? '0 : dict_rdata_i.length;
    olen_c    = {1'b0, plen_c} + {{LEN_W{1'b0}}, ~tag_q};
    next_c    = {1'b0, bytes_q} + (FS_W + 1)'(olen_c);
    bytes_inc = bytes_q + 1'b1;
    fd_c      = (bytes_inc == cfg_i.frame_size);
    last_c    = ((e_q + 1'b1) == olen_q);
    pref_m1   = dict_rdata_i.prefix - 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    bytes_d    = bytes_q;
    k_d        = k_q;
    e_d        = e_q;
    zero_d     = zero_q;
    load_tok   = 1'b0;
    load_len   = 1'b0;
    in_ready_o = 1'b0;
    dict_req_o = '0;
    buf_we     = 1'b0;
    buf_waddr  = '0;
    buf_wdata  = '0;
    res_valid_o = 1'b0;
    res_o      = '0;

    if (cfg_i.fs_we && (phase_q == PH_COLLECT || phase_q == PH_DONE)) begin
      phase_d = (bytes_q == cfg_i.fs_wdata) ? PH_DONE : PH_COLLECT;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_tok         = 1'b1;
          dict_req_o.re    = 1'b1;
          dict_req_o.raddr = DICT_AW'(ref_idx_i - 1'b1);
          state_d          = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (phase_q == PH_ERR_BAD || phase_q == PH_ERR_LONG) begin
          state_d = ST_ERR;
        end else if (phase_q == PH_DONE || idx_q > count_q || (tag_q && idx_q == '0)) begin
          phase_d = PH_ERR_BAD;
          state_d = ST_ERR;
        end else if (olen_c > (LEN_W + 1)'(MAX_PHRASE) || plen_c > LEN_W'(MAX_PHRASE)) begin
          phase_d = PH_ERR_LONG;
          state_d = ST_ERR;
        end else if (next_c > {1'b0, cfg_i.frame_size} ||
                     (tag_q && next_c != {1'b0, cfg_i.frame_size})) begin
          phase_d = PH_ERR_BAD;
          state_d = ST_ERR;
        end else begin
          load_len = 1'b1;
          if (!tag_q && count_q < cfg_i.max_entries && count_q < IDX_W'(DICT_DEPTH)) begin
            dict_req_o.we            = 1'b1;
            dict_req_o.waddr         = count_q[DICT_AW-1:0];
            dict_req_o.wentry.prefix = idx_q;
            dict_req_o.wentry.symbol = sym_q;
            dict_req_o.wentry.length = olen_c[LEN_W-1:0];
            count_d                  = count_q + 1'b1;
          end
          if (plen_c != '0) begin
            buf_we           = 1'b1;
            buf_waddr        = BUF_AW'(plen_c - 1'b1);
            buf_wdata        = dict_rdata_i.symbol;
            dict_req_o.re    = 1'b1;
            dict_req_o.raddr = pref_m1[DICT_AW-1:0];
            zero_d           = (dict_rdata_i.prefix == '0);
            k_d              = plen_c - 1'b1;
            state_d          = ST_WALK;
          end else begin
            e_d     = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (k_q == '0) begin
          e_d     = '0;
          state_d = ST_EMIT;
        end else begin
          buf_we           = 1'b1;
          buf_waddr        = BUF_AW'(k_q - 1'b1);
          buf_wdata        = zero_q ? '0 : dict_rdata_i.symbol;
          dict_req_o.re    = 1'b1;
          dict_req_o.raddr = pref_m1[DICT_AW-1:0];
          zero_d           = zero_q | (dict_rdata_i.prefix == '0);
          k_d              = k_q - 1'b1;
        end
      end
      ST_EMIT: begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = (e_q < plen_q) ? buf_rd_q : sym_q;
        res_o.status     = STAT_OK;
        res_o.frame_done = fd_c;
        res_o.last       = last_c;
        if (res_ready_i) begin
          bytes_d = bytes_inc;
          e_d     = e_q + 1'b1;
          if (last_c) begin
            phase_d = fd_c ? PH_DONE : PH_COLLECT;
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = '0;
        res_o.status     = (phase_q == PH_ERR_LONG) ? STAT_LONG : STAT_BAD;
        res_o.frame_done = 1'b0;
        res_o.last       = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DONE;
      count_q <= '0;
      bytes_q <= '0;
      k_q     <= '0;
      e_q     <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
      k_q     <= k_d;
      e_q     <= e_d;
      zero_q  <= zero_d;
    end
  end

  // token fields and phrase lengths
  always_ff @(posedge clk_i) begin
    if (load_tok) begin
      tag_q <= tag_i;
      idx_q <= ref_idx_i;
      sym_q <= symbol_i;
    end
    if (load_len) begin
      plen_q <= plen_c;
      olen_q <= olen_c[LEN_W-1:0];
    end
  end

  // phrase buffer, read address follows the emit counter
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rd_q <= buf_mem[e_d[BUF_AW-1:0]];
  end

endmodule

@@ hdl/lz78_token_decoder.sv @@
// ----------------------------------------------------------------------------
// lz78_token_decoder
// LZ78 token decoder: expands pair and final tokens into a byte stream
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one token per transfer; tuser[0] is the tag (0 pair,
//   1 final), tdata holds the reference index and symbol. m_axis carries one
//   decoded byte per transfer with status and frame_done in tuser and tlast on
//   the final byte of each token. APB sets frame_size (0x0) and max_entries
//   (0x4); the user writes them only while the block is idle, which the
//   block does not enforce. a token occupies the block through these steps,
//   in order: the dictionary read of the referenced entry, a check step
//   that also takes the first prefix link, one step per further link, a
//   step to turn the phrase buffer around, then one step per emitted byte.
//   an error token goes from the check step to a single error result.
//   s_axis_tready is high only between tokens.
//   when the receiver stalls, the output register holds its byte and the
//   sequencer waits; no byte is dropped.
//   reset empties the dictionary, zeroes the byte count and leaves the decoder
//   done with frame_size 0, so frame_size must be written before a frame.
// ----------------------------------------------------------------------------
`include "lz78_token_decoder_assert.svh"

module lz78_token_decoder import lz78d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // ref_index[12:0], symbol[20:13]
  input  logic [0:0]  s_axis_tuser,   // tag[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic [2:0]  m_axis_tuser,   // status[1:0], frame_done[2]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FS_W-1:0]  frame_size_q;
  logic [IDX_W-1:0] max_entries_q;
  logic             cfg_wr;
  cfg_t             cfg;

  dict_req_t        dict_req;
  entry_t           dict_rdata;

  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_res_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q  <= '0;
      max_entries_q <= IDX_W'(DICT_DEPTH);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_SIZE:  frame_size_q  <= pwdata;
        REG_MAX_ENTRIES: max_entries_q <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_SIZE:  prdata = frame_size_q;
      REG_MAX_ENTRIES: prdata = {{(32 - IDX_W){1'b0}}, max_entries_q};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.frame_size  = frame_size_q;
    cfg.max_entries = max_entries_q;
    cfg.fs_we       = cfg_wr && (paddr[2] == REG_FRAME_SIZE);
    cfg.fs_wdata    = pwdata;
  end

  lz78d_dict u_dict (
    .clk_i   (clk_i),
    .req_i   (dict_req),
    .rdata_o (dict_rdata)
  );

  lz78d_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .tag_i          (s_axis_tuser[0]),
    .ref_idx_i      (s_axis_tdata[IDX_W-1:0]),
    .symbol_i       (s_axis_tdata[IDX_W+SYM_W-1:IDX_W]),
    .cfg_i          (cfg),
    .dict_req_o     (dict_req),
    .dict_rdata_i   (dict_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.out_byte;
  assign m_axis_tuser  = {out_res_q.frame_done, out_res_q.status};
  assign m_axis_tlast  = out_res_q.last;

  `LZD_ASSERT_NEXT(a_busy_after_token, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LZD_ASSERT_IMPL(a_err_result_shape, m_axis_tvalid && (m_axis_tuser[1:0] != STAT_OK), (m_axis_tdata == '0) && !m_axis_tuser[2] && m_axis_tlast)
  `LZD_ASSERT_IMPL(a_frame_done_last, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lz78 token decoder: tokens go in on the slave
// stream, decoded bytes are checked against a dictionary model kept here,
// with random stalls on both streams and apb register writes between frames
// ----------------------------------------------------------------------------
module testbench;
  import lz78d_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 390;

  typedef enum int unsigned {
    ERR_AFTER_DONE,
    ERR_BAD_INDEX,
    ERR_EMPTY_FINAL,
    ERR_TOO_LONG,
    ERR_OVERRUN,
    ERR_SHORT_FINAL
  } err_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // dictionary model
  logic [IDX_W-1:0] ent_prefix [DICT_DEPTH];
  logic [SYM_W-1:0] ent_symbol [DICT_DEPTH];
  logic [6:0]       ent_length [DICT_DEPTH];
  int unsigned      entry_count = 0;
  logic [31:0]      bytes_emitted = '0;
  logic [31:0]      frame_size = '0;
  int unsigned      max_entries = DICT_DEPTH;
  phase_e           dec_phase = PH_DONE;

  res_t        pending_bytes [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned long_idx = 0;
  bit          quiet = 1'b0;

  lz78_token_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lz78_token_decoder: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk_i) begin : check_output
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tlast};
      if (pending_bytes.size() == 0) begin
        fail_count++;
        $display("%0t expected no transfer, got byte %02h status %0d done %0b last %0b",
                 $time, got.out_byte, got.status, got.frame_done, got.last);
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          fail_count++;
          $display({"%0t expected byte %02h status %0d done %0b last %0b, ",
                    "got byte %02h status %0d done %0b last %0b"}, $time,
                   want.out_byte, want.status, want.frame_done, want.last,
                   got.out_byte, got.status, got.frame_done, got.last);
        end
      end
    end
  end

  function automatic int unsigned phrase_len(input int unsigned idx);
    return (idx == 0) ? 0 : int'(ent_length[idx-1]);
  endfunction

  task automatic decode_token(input logic tag, input logic [IDX_W-1:0] idx,
                              input logic [SYM_W-1:0] sym);
    int unsigned      plen;
    int unsigned      olen;
    int unsigned      k;
    longint unsigned  total;
    logic [SYM_W-1:0] phrase [MAX_PHRASE];
    logic [IDX_W-1:0] walk;
    phase_e           err;
    res_t             r;
    err = PH_COLLECT;
    plen = 0;
    olen = 0;
    if (dec_phase == PH_ERR_BAD || dec_phase == PH_ERR_LONG) begin
      err = dec_phase;
    end else if (dec_phase == PH_DONE || idx > entry_count) begin
      err = PH_ERR_BAD;
    end else begin
      plen = phrase_len(idx);
      olen = tag ? plen : plen + 1;
      if (tag && idx == 0) begin
        err = PH_ERR_BAD;
      end else if (olen > MAX_PHRASE) begin
        err = PH_ERR_LONG;
      end else begin
        total = longint'(bytes_emitted) + olen;
        if (total > frame_size || (tag && total != frame_size)) err = PH_ERR_BAD;
      end
    end
    if (err != PH_COLLECT) begin
      dec_phase = err;
      r.out_byte = '0;
      r.status = (err == PH_ERR_LONG) ? STAT_LONG : STAT_BAD;
      r.frame_done = 1'b0;
      r.last = 1'b1;
      pending_bytes.push_back(r);
      return;
    end
    // phrase is filled from its end while following the prefix links
    walk = idx;
    for (k = plen; k > 0; k--) begin
      phrase[k-1] = ent_symbol[walk-1];
      walk = ent_prefix[walk-1];
    end
    if (!tag && entry_count < max_entries && entry_count < DICT_DEPTH) begin
      ent_prefix[entry_count] = idx;
      ent_symbol[entry_count] = sym;
      ent_length[entry_count] = 7'(olen);
      entry_count++;
    end
    for (k = 0; k < olen; k++) begin
      bytes_emitted++;
      r.out_byte = (k < plen) ? phrase[k] : sym;
      r.status = STAT_OK;
      r.frame_done = (bytes_emitted == frame_size);
      r.last = (k + 1 == olen);
      pending_bytes.push_back(r);
    end
    dec_phase = (bytes_emitted == frame_size) ? PH_DONE : PH_COLLECT;
  endtask

  task automatic send_token(input logic tag, input logic [IDX_W-1:0] idx,
                            input logic [SYM_W-1:0] sym);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, sym, idx};
    s_axis_tuser <= tag;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_token(tag, idx, sym);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_FRAME_SIZE) begin
      frame_size = value;
      if (dec_phase == PH_COLLECT || dec_phase == PH_DONE)
        dec_phase = (bytes_emitted == frame_size) ? PH_DONE : PH_COLLECT;
    end else begin
      max_entries = value[IDX_W-1:0];
    end
    // read back through a second transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    want = (sel == REG_FRAME_SIZE) ? frame_size : 32'(max_entries);
    if (readback !== want) begin
      fail_count++;
      $display("%0t register %0d expected %08h, got %08h", $time, sel, want, readback);
    end
    @(posedge clk_i);
  endtask

  task automatic test_basic();
    set_reg(REG_MAX_ENTRIES, DICT_DEPTH);
    set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
    send_token(1'b0, 0, 8'h00);
    send_token(1'b0, 0, 8'hFF);
    send_token(1'b0, 1, 8'hA5);
    send_token(1'b0, 3, 8'h5A);
    send_token(1'b0, 2, 8'h80);
    send_token(1'b0, 4, 8'h7F);
  endtask

  task automatic test_frame_end();
    set_reg(REG_FRAME_SIZE, bytes_emitted + 3);
    send_token(1'b0, 0, 8'h11);
    send_token(1'b1, 3, 8'h00);
    set_reg(REG_FRAME_SIZE, bytes_emitted);
    set_reg(REG_FRAME_SIZE, 32'h0);
    set_reg(REG_FRAME_SIZE, bytes_emitted + 2);
    send_token(1'b0, 1, 8'h22);
    set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
  endtask

  task automatic test_dict_limit();
    set_reg(REG_MAX_ENTRIES, entry_count);
    send_token(1'b0, 2, 8'h33);
    send_token(1'b0, IDX_W'(entry_count), 8'hC3);
    set_reg(REG_MAX_ENTRIES, 0);
    send_token(1'b0, 0, 8'h44);
    send_token(1'b0, 6, 8'h01);
    set_reg(REG_MAX_ENTRIES, DICT_DEPTH);
    send_token(1'b0, 6, 8'hFE);
  endtask

  task automatic test_longest_phrase();
    int unsigned prev;
    prev = 0;
    set_reg(REG_MAX_ENTRIES, DICT_DEPTH);
    set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
    repeat (MAX_PHRASE) begin
      send_token(1'b0, IDX_W'(prev), SYM_W'($urandom));
      prev = entry_count;
    end
    long_idx = prev;
    set_reg(REG_FRAME_SIZE, bytes_emitted + MAX_PHRASE);
    send_token(1'b1, IDX_W'(long_idx), SYM_W'($urandom));
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned remaining;
    int unsigned idx;
    int unsigned cand;
    int unsigned start;
    int unsigned n;
    bit          found;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= 200 && sent < 300);
      case ($urandom_range(0, 3))
        0: set_reg(REG_MAX_ENTRIES, DICT_DEPTH);
        1: set_reg(REG_MAX_ENTRIES, entry_count + $urandom_range(0, 24));
        2: set_reg(REG_MAX_ENTRIES, $urandom_range(0, DICT_DEPTH));
        default: ;
      endcase
      set_reg(REG_FRAME_SIZE, bytes_emitted +
              (($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 160)));
      remaining = frame_size - bytes_emitted;
      while (remaining != 0) begin
        found = 1'b0;
        idx = 0;
        if (entry_count != 0 && $urandom_range(0, 2) == 0) begin
          start = $urandom_range(0, entry_count - 1);
          for (n = 0; n < entry_count && !found; n++) begin
            idx = (start + n) % entry_count + 1;
            found = (phrase_len(idx) == remaining);
          end
        end
        if (found) begin
          send_token(1'b1, IDX_W'(idx), SYM_W'($urandom));
        end else begin
          // longest usable phrase out of a few random picks
          idx = 0;
          repeat (8) begin
            cand = ($urandom_range(0, 1) == 0) ? $urandom_range(0, entry_count) :
                   entry_count - $urandom_range(0, (entry_count < 16) ? entry_count : 16);
            if (phrase_len(cand) < remaining && phrase_len(cand) < MAX_PHRASE &&
                phrase_len(cand) > phrase_len(idx))
              idx = cand;
          end
          send_token(1'b0, IDX_W'(idx), SYM_W'($urandom));
        end
        sent++;
        remaining = frame_size - bytes_emitted;
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_errors();
    err_kind_e kind;
    kind = err_kind_e'($urandom_range(0, 5));
    case (kind)
      ERR_AFTER_DONE: begin
        set_reg(REG_FRAME_SIZE, bytes_emitted);
        send_token(1'b0, 0, SYM_W'($urandom));
      end
      ERR_BAD_INDEX: begin
        set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
        send_token(1'($urandom), IDX_W'($urandom_range(entry_count + 1, 8191)),
                   SYM_W'($urandom));
      end
      ERR_EMPTY_FINAL: begin
        set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
        send_token(1'b1, 0, SYM_W'($urandom));
      end
      ERR_TOO_LONG: begin
        set_reg(REG_FRAME_SIZE, 32'hFFFF_FFFF);
        send_token(1'b0, IDX_W'(long_idx), SYM_W'($urandom));
      end
      ERR_OVERRUN: begin
        set_reg(REG_FRAME_SIZE, bytes_emitted + 1);
        send_token(1'b0, 1, SYM_W'($urandom));
      end
      default: begin
        set_reg(REG_FRAME_SIZE, bytes_emitted + 100);
        send_token(1'b1, 1, SYM_W'($urandom));
      end
    endcase
    // the error holds across a frame size write and any later token
    set_reg(REG_FRAME_SIZE, $urandom);
    repeat (12) send_token(1'($urandom), IDX_W'($urandom_range(0, 8191)), SYM_W'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic();
    test_frame_end();
    test_dict_limit();
    test_longest_phrase();
    test_random_frames();
    test_errors();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("lz78_token_decoder: match");
    end else begin
      $display("lz78_token_decoder: mismatch");
    end
    $finish;
  end

endmodule
